// ===== rtl/pwle_pkg.sv =====
// Package for the pulse width line encoder: widths, item and result types, helpers.
package pwle_pkg;

	localparam int COUNT_WIDTH = 24;
	localparam int CFG_WIDTH = 24;
	localparam int LEN_WIDTH = ((COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH) + 1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int NUM_REGS = 3;
	localparam int ADDR_W = $clog2(NUM_REGS) + 2;

	localparam logic [ADDR_W-3:0] REG_SYNC = 0;
	localparam logic [ADDR_W-3:0] REG_SHORT = 1;
	localparam logic [ADDR_W-3:0] REG_LONG = 2;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_SYNC = 5'b00010,
		PH_CAL  = 5'b00100,
		PH_BHI  = 5'b01000,
		PH_BLO  = 5'b10000
	} phase_t;

	typedef struct packed {
		logic       offer;
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic line_level;
		logic byte_taken;
		logic frame_active;
		logic underrun;
	} result_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] sync_ticks;
		logic [CFG_WIDTH-1:0] short_pulse_ticks;
		logic [CFG_WIDTH-1:0] long_pulse_ticks;
	} cfg_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
	} q_stat_t;

	// Segment length: zero acts as one tick, and lengths saturate at 2^COUNT_WIDTH.
	function automatic logic [LEN_WIDTH-1:0] seg_len(input logic [CFG_WIDTH-1:0] reg_val);
		logic [LEN_WIDTH-1:0] n;
		logic [LEN_WIDTH-1:0] cap;
		cap = LEN_WIDTH'(1) << COUNT_WIDTH;
		n = LEN_WIDTH'(reg_val);
		if (n == '0) begin
			n = LEN_WIDTH'(1);
		end
		if (n > cap) begin
			n = cap;
		end
		return n;
	endfunction

endpackage

// ===== rtl/pwle_front.sv =====
// Front end: accepts tick items, classifies them and queues them for the back end.
module pwle_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	input  logic [7:0]           data_byte,
	input  logic                 frame_end,
	output pwle_pkg::item_t      head,
	output logic                 head_valid,
	input  logic                 pop,
	output pwle_pkg::q_stat_t    q_stat
);
	import pwle_pkg::*;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	item_t             item_in;
	logic              push;
	logic              do_pop;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	// A tick that does not offer a byte carries no byte or last mark.
	always_comb begin
		item_in.offer = func;
		item_in.data = func ? data_byte : 8'h00;
		item_in.last = func & frame_end;
	end

	assign in_ready = (count_q != QCNT_W'(QDEPTH));
	assign push = in_valid && in_ready;
	assign head_valid = (count_q != '0);
	assign do_pop = pop && head_valid;
	assign head = mem_q[rd_ptr_q];
	assign q_stat.count = count_q;
	assign q_stat.full = !in_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, do_pop})
				2'b10: count_q <= count_q + QCNT_W'(1);
				2'b01: count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/pwle_back.sv =====
// Back end: line sequencer, holding register and result register.
module pwle_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pwle_pkg::cfg_t    cfg,
	input  pwle_pkg::item_t   head,
	input  logic              head_valid,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output pwle_pkg::result_t res
);
	import pwle_pkg::*;

	phase_t                 phase_q;
	logic [COUNT_WIDTH-1:0] tick_count_q;
	logic [7:0]             shift_byte_q;
	logic [2:0]             bit_index_q;
	logic                   shift_is_last_q;
	logic [7:0]             hold_byte_q;
	logic                   hold_valid_q;
	logic                   hold_last_q;
	logic                   out_valid_q;
	result_t                res_q;

	logic                   cur_bit;
	logic [CFG_WIDTH-1:0]   len_reg;
	logic [LEN_WIDTH-1:0]   len;
	logic                   seg_done;
	logic                   level;
	logic                   active;
	logic                   under;
	logic                   load_hold;
	logic                   taken;
	phase_t                 phase_d;

	assign pop = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res = res_q;
	assign cur_bit = shift_byte_q[bit_index_q];
	assign len = seg_len(len_reg);
	assign seg_done = (LEN_WIDTH'(tick_count_q) + LEN_WIDTH'(1)) >= len;
	assign taken = head.offer && !hold_valid_q;

	always_comb begin
		level = 1'b1;
		active = 1'b1;
		len_reg = cfg.short_pulse_ticks;
		case (phase_q)
			PH_SYNC: begin
				level = 1'b0;
				len_reg = cfg.sync_ticks;
			end
			PH_CAL: begin
				len_reg = cfg.short_pulse_ticks;
			end
			PH_BHI: begin
				len_reg = cur_bit ? cfg.short_pulse_ticks : cfg.long_pulse_ticks;
			end
			PH_BLO: begin
				level = 1'b0;
				len_reg = cur_bit ? cfg.long_pulse_ticks : cfg.short_pulse_ticks;
			end
			default: begin
				active = 1'b0;
			end
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		under = 1'b0;
		load_hold = 1'b0;
		if (!active) begin
			phase_d = PH_IDLE;
			if (hold_valid_q) begin
				load_hold = 1'b1;
				phase_d = PH_SYNC;
			end
		end else if (seg_done) begin
			case (phase_q)
				PH_SYNC: phase_d = PH_CAL;
				PH_CAL: phase_d = PH_BHI;
				PH_BHI: phase_d = PH_BLO;
				default: begin
					if (bit_index_q != 3'd0) begin
						phase_d = PH_BHI;
					end else if (shift_is_last_q) begin
						phase_d = PH_IDLE;
					end else if (hold_valid_q) begin
						load_hold = 1'b1;
						phase_d = PH_BHI;
					end else begin
						under = 1'b1;
						phase_d = PH_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && taken) begin
			hold_byte_q <= head.data;
		end
		if (pop) begin
			res_q.line_level <= level;
			res_q.byte_taken <= taken;
			res_q.frame_active <= active;
			res_q.underrun <= under;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_count_q <= '0;
			shift_byte_q <= '0;
			bit_index_q <= 3'd7;
			shift_is_last_q <= 1'b0;
			hold_valid_q <= 1'b0;
			hold_last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				phase_q <= phase_d;
				if (!active || seg_done) begin
					tick_count_q <= '0;
				end else begin
					tick_count_q <= tick_count_q + COUNT_WIDTH'(1);
				end
				if (active && seg_done && phase_q == PH_BLO && bit_index_q != 3'd0) begin
					bit_index_q <= bit_index_q - 3'd1;
				end
				if (load_hold) begin
					shift_byte_q <= hold_byte_q;
					shift_is_last_q <= hold_last_q;
					bit_index_q <= 3'd7;
				end
				// The holding register refills only if it was empty at the start of the tick.
				if (taken) begin
					hold_valid_q <= 1'b1;
					hold_last_q <= head.last;
				end else if (load_hold) begin
					hold_valid_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== rtl/pulse_width_line_encoder.sv =====
// Top level of the pulse width line encoder: register port, front end and back end.
//
// Every input transfer is one tick of the line timebase and yields exactly one
// result transfer that gives the line level for that tick, whether a byte
// offered on that tick went into the one-byte holding register, whether a
// frame is on the line, and an underrun flag on the tick a frame ends because
// no further byte was held. The line idles high; a frame is a low sync period
// of sync_ticks, a high calibration pulse of short_pulse_ticks, then each bit
// MSB first (a one is short high then long low, a zero is long high then short
// low). A zero length register acts as one tick. The block takes one tick per
// clock cycle while the receiver takes results: a two-entry queue sits behind
// the input, and the back end's sequencer updates its segment counter, shifter
// and holding register for each tick, with the result held in an output
// register that is refilled in the same cycle it is taken. Registers are
// written through the APB port at byte addresses 0, 4 and 8; the user must do so
// only while no tick is in flight, as the block itself does not enforce it.
module pulse_width_line_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pwle_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [7:0]                    data_byte,
	input  logic                          frame_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          line_level,
	output logic                          byte_taken,
	output logic                          frame_active,
	output logic                          underrun
);
	import pwle_pkg::*;

	cfg_t    cfg_q;
	item_t   head;
	logic    head_valid;
	logic    pop;
	q_stat_t q_stat;
	result_t res;
	logic    wr_en;
	logic [ADDR_W-3:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];

	// Register writes; an address past the last register is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_ticks <= CFG_WIDTH'(310000);
			cfg_q.short_pulse_ticks <= CFG_WIDTH'(4992);
			cfg_q.long_pulse_ticks <= CFG_WIDTH'(9984);
		end else if (wr_en) begin
			case (reg_idx)
				REG_SYNC: cfg_q.sync_ticks <= pwdata[CFG_WIDTH-1:0];
				REG_SHORT: cfg_q.short_pulse_ticks <= pwdata[CFG_WIDTH-1:0];
				REG_LONG: cfg_q.long_pulse_ticks <= pwdata[CFG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SYNC: prdata = 32'(cfg_q.sync_ticks);
			REG_SHORT: prdata = 32'(cfg_q.short_pulse_ticks);
			REG_LONG: prdata = 32'(cfg_q.long_pulse_ticks);
			default: prdata = 32'h0;
		endcase
	end

	pwle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.data_byte  (data_byte),
		.frame_end  (frame_end),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.q_stat     (q_stat)
	);

	pwle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res        (res)
	);

	assign line_level = res.line_level;
	assign byte_taken = res.byte_taken;
	assign frame_active = res.frame_active;
	assign underrun = res.underrun;

	// An underrun can only be flagged at the end of a low bit segment inside a frame.
	a_underrun_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && underrun |-> frame_active && !line_level)
		else $error("underrun flagged outside a low bit segment");

	// Outside a frame the line must idle high.
	a_idle_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_active |-> line_level)
		else $error("line driven low outside a frame");

	// The queue never holds more ticks than it has entries, and reports full consistently.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.count <= QCNT_W'(QDEPTH)) && (q_stat.full == (q_stat.count == QCNT_W'(QDEPTH))))
		else $error("tick queue count out of range");

endmodule

// ===== verif/pulse_width_line_encoder_test.sv =====
// Self-checking testbench for the pulse width line encoder: directed frames, random traffic, back pressure.
module pulse_width_line_encoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pwle_pkg::*;

	// The run is far shorter than this. Hitting the limit means the block has hung.
	localparam int CYCLE_LIMIT = 400000;
	// Cycles allowed after the last result.
	localparam int SETTLE_CYCLES = 8;
	localparam logic [CFG_WIDTH-1:0] CFG_MAX = '1;

	// Receiver behavior while results are being taken.
	typedef enum int {
		RCV_ALWAYS,
		RCV_LIGHT,
		RCV_HEAVY,
		RCV_PERIODIC
	} rcv_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 func = 1'b0;
	logic [7:0]           data_byte = 8'h00;
	logic                 frame_end = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 line_level;
	logic                 byte_taken;
	logic                 frame_active;
	logic                 underrun;

	// Predicted encoder state, kept in step with every accepted tick transfer.
	cfg_t                 enc_cfg = '{sync_ticks: 24'd310000, short_pulse_ticks: 24'd4992,
		long_pulse_ticks: 24'd9984};
	phase_t               enc_phase = PH_IDLE;
	logic [COUNT_WIDTH-1:0] enc_count = '0;
	logic [7:0]           enc_shift = 8'h00;
	logic [2:0]           enc_bit = 3'd7;
	logic                 enc_shift_last = 1'b0;
	logic [7:0]           enc_hold = 8'h00;
	logic                 enc_hold_valid = 1'b0;
	logic                 enc_hold_last = 1'b0;

	// Predicted line results, oldest first, one per accepted tick.
	result_t              expected_line[$];

	int                   mismatch_count = 0;
	int                   cycle_count = 0;

	// Sender pacing: bursts of back to back transfers separated by gaps no longer than gap_max.
	int                   gap_max = 0;
	int                   burst_left = 0;

	// Receiver pacing and the long hold-off used to fill the block.
	rcv_mode_t            rcv_mode = RCV_ALWAYS;
	int                   hold_off_request = 0;
	int                   hold_off_left = 0;
	int                   rcv_phase = 0;

	pulse_width_line_encoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.data_byte    (data_byte),
		.frame_end    (frame_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.line_level   (line_level),
		.byte_taken   (byte_taken),
		.frame_active (frame_active),
		.underrun     (underrun)
	);

	always #5 clk = ~clk;

	// Global watchdog. A correct run never gets close to the limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Length of a segment in ticks. A zero register acts as one tick, and the
	// counter cannot count past 2^COUNT_WIDTH.
	function automatic longint unsigned segment_ticks(input logic [CFG_WIDTH-1:0] reg_val);
		longint unsigned n;
		longint unsigned cap;
		cap = 64'd1 << COUNT_WIDTH;
		n = 64'(reg_val);
		if (n == 0) begin
			n = 1;
		end
		if (n > cap) begin
			n = cap;
		end
		return n;
	endfunction

	// Move the held byte into the shifter, starting again at the MSB.
	function automatic void load_shifter();
		enc_shift = enc_hold;
		enc_shift_last = enc_hold_last;
		enc_bit = 3'd7;
		enc_hold_valid = 1'b0;
	endfunction

	// Advance the predicted encoder by one tick and return what the line does on it.
	// The next segment is chosen from the holding register as it stood at the start
	// of the tick. The offered byte is then taken only if that register was empty.
	function automatic result_t encode_tick(input item_t tick);
		result_t         res;
		logic            had_hold;
		logic            cur_bit;
		longint unsigned seg_len;
		longint unsigned count_next;
		phase_t          next_phase;
		had_hold = enc_hold_valid;
		cur_bit = enc_shift[enc_bit];
		res = '0;
		res.line_level = 1'b1;
		res.frame_active = 1'b1;
		seg_len = 1;
		next_phase = PH_IDLE;
		case (enc_phase)
			PH_SYNC: begin
				res.line_level = 1'b0;
				seg_len = segment_ticks(enc_cfg.sync_ticks);
				next_phase = PH_CAL;
			end
			PH_CAL: begin
				seg_len = segment_ticks(enc_cfg.short_pulse_ticks);
				next_phase = PH_BHI;
			end
			PH_BHI: begin
				seg_len = segment_ticks(cur_bit ? enc_cfg.short_pulse_ticks
					: enc_cfg.long_pulse_ticks);
				next_phase = PH_BLO;
			end
			PH_BLO: begin
				res.line_level = 1'b0;
				seg_len = segment_ticks(cur_bit ? enc_cfg.long_pulse_ticks
					: enc_cfg.short_pulse_ticks);
				next_phase = PH_BHI;
			end
			default: begin
				res.frame_active = 1'b0;
			end
		endcase

		count_next = 64'(enc_count);
		count_next = count_next + 1;
		if (!res.frame_active) begin
			enc_phase = PH_IDLE;
			enc_count = '0;
			if (had_hold) begin
				load_shifter();
				enc_phase = PH_SYNC;
			end
		end else if (count_next >= seg_len) begin
			enc_count = '0;
			if (enc_phase == PH_BLO) begin
				if (enc_bit != 3'd0) begin
					enc_bit = enc_bit - 3'd1;
					enc_phase = PH_BHI;
				end else if (enc_shift_last) begin
					enc_phase = PH_IDLE;
				end else if (had_hold) begin
					load_shifter();
					enc_phase = PH_BHI;
				end else begin
					res.underrun = 1'b1;
					enc_phase = PH_IDLE;
				end
			end else begin
				enc_phase = next_phase;
			end
		end else begin
			enc_count = enc_count + COUNT_WIDTH'(1);
		end

		if (tick.offer && !had_hold) begin
			enc_hold = tick.data;
			enc_hold_last = tick.last;
			enc_hold_valid = 1'b1;
			res.byte_taken = 1'b1;
		end
		return res;
	endfunction

	// Offer one tick transfer and hold it until the block accepts it. Gaps fall
	// between bursts, so valid only drops at a burst boundary.
	task automatic send_tick(input logic offer, input logic [7:0] data, input logic last);
		item_t tick;
		int    gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		tick.offer = offer;
		tick.data = data;
		tick.last = last;
		@(negedge clk);
		in_valid <= 1'b1;
		func <= offer;
		data_byte <= data;
		frame_end <= last;
		do @(posedge clk); while (!in_ready);
		expected_line.push_back(encode_tick(tick));
	endtask

	// Let any frame run out with plain ticks, then wait until every result has
	// been taken, so that the block is idle before its registers change.
	task automatic settle();
		while (enc_phase != PH_IDLE || enc_hold_valid) begin
			send_tick(1'b0, 8'($urandom), 1'($urandom));
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_line.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write: a setup phase, then an access phase held until pready.
	// The register is then read back.
	task automatic write_reg(input logic [ADDR_W-3:0] idx, input logic [CFG_WIDTH-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SYNC:  enc_cfg.sync_ticks = val;
			REG_SHORT: enc_cfg.short_pulse_ticks = val;
			REG_LONG:  enc_cfg.long_pulse_ticks = val;
			default: ;
		endcase
		@(posedge clk);
		if (prdata !== 32'(val)) begin
			$error("prdata mismatch: expected %0h, actual %0h", 32'(val), prdata);
			mismatch_count++;
		end
	endtask

	task automatic set_timing(input logic [CFG_WIDTH-1:0] sync_len,
		input logic [CFG_WIDTH-1:0] short_len, input logic [CFG_WIDTH-1:0] long_len);
		settle();
		write_reg(REG_SYNC, sync_len);
		write_reg(REG_SHORT, short_len);
		write_reg(REG_LONG, long_len);
	endtask

	// Receiver: a long hold-off when one is requested, otherwise the current mode.
	always @(negedge clk) begin
		if (hold_off_request != 0) begin
			hold_off_left = hold_off_request;
			hold_off_request = 0;
		end
		rcv_phase++;
		if (hold_off_left != 0) begin
			hold_off_left--;
			out_ready <= 1'b0;
		end else begin
			case (rcv_mode)
				RCV_LIGHT:    out_ready <= ($urandom_range(3, 0) != 0);
				RCV_HEAVY:    out_ready <= ($urandom_range(3, 0) == 0);
				RCV_PERIODIC: out_ready <= ((rcv_phase % 7) < 4);
				default:      out_ready <= 1'b1;
			endcase
		end
	end

	function automatic void check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			$error("%s mismatch: expected %0b, actual %0b", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Every result transfer is compared with the oldest prediction.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_line.size() == 0) begin
				$error("result transfer with no tick pending");
				mismatch_count++;
			end else begin
				want = expected_line.pop_front();
				check_field("line_level", want.line_level, line_level);
				check_field("byte_taken", want.byte_taken, byte_taken);
				check_field("frame_active", want.frame_active, frame_active);
				check_field("underrun", want.underrun, underrun);
			end
		end
	end

	// With the reset timing the line just idles high; data on plain ticks is ignored.
	task automatic test_reset_idle();
		repeat (12) send_tick(1'b0, 8'($urandom), 1'($urandom));
	endtask

	// Single byte frames with all bits low and all bits high.
	task automatic test_field_extremes();
		set_timing(24'd2, 24'd1, 24'd3);
		send_tick(1'b1, 8'h00, 1'b1);
		settle();
		send_tick(1'b1, 8'hFF, 1'b1);
		settle();
	endtask

	// The byte offered on the tick the held byte moves to the shifter is still
	// refused, since the register was full at the start of that tick.
	task automatic test_offer_while_full();
		send_tick(1'b1, 8'h3C, 1'b0);
		send_tick(1'b1, 8'hC3, 1'b1);
		send_tick(1'b1, 8'hC3, 1'b1);
		send_tick(1'b1, 8'h99, 1'b0);
		settle();
	endtask

	// A byte not marked last with nothing behind it ends the frame in underrun.
	// Then a second byte arrives in time and the frame carries on into it.
	task automatic test_chain_and_underrun();
		send_tick(1'b1, 8'hA5, 1'b0);
		settle();
		send_tick(1'b1, 8'h5A, 1'b0);
		repeat (6) send_tick(1'b0, 8'h00, 1'b0);
		send_tick(1'b1, 8'h81, 1'b1);
		settle();
	endtask

	// All length registers at zero: every segment is a single tick.
	task automatic test_zero_lengths();
		set_timing(24'd0, 24'd0, 24'd0);
		send_tick(1'b1, 8'h96, 1'b0);
		send_tick(1'b0, 8'hFF, 1'b1);
		send_tick(1'b1, 8'h69, 1'b1);
		settle();
	endtask

	// Random ticks. The offer rate decides whether frames chain or run dry.
	task automatic test_random_frames(input int count, input int offer_pct, input int last_pct);
		repeat (count) begin
			send_tick(1'($urandom_range(99, 0) < offer_pct), 8'($urandom),
				1'($urandom_range(99, 0) < last_pct));
		end
	endtask

	// The receiver stops for a long stretch while the sender keeps offering, so
	// the internal queue fills and input transfers stall.
	task automatic test_backpressure();
		settle();
		gap_max = 0;
		rcv_mode = RCV_ALWAYS;
		hold_off_request = 150;
		test_random_frames(60, 20, 40);
	endtask

	// Largest register values. The sync period then outlasts the run, so this
	// test comes last and leaves the frame in its sync period.
	task automatic test_longest_lengths();
		set_timing(CFG_MAX, CFG_MAX, CFG_MAX);
		gap_max = 3;
		rcv_mode = RCV_PERIODIC;
		repeat (10) send_tick(1'b0, 8'($urandom), 1'($urandom));
		send_tick(1'b1, 8'hC3, 1'b1);
		repeat (100) send_tick(1'b0, 8'($urandom), 1'($urandom));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_idle();
		test_field_extremes();
		test_offer_while_full();
		test_chain_and_underrun();
		test_zero_lengths();

		// Random traffic over a spread of timings and pacing.
		set_timing(24'd3, 24'd1, 24'd3);
		gap_max = 0;
		rcv_mode = RCV_ALWAYS;
		test_random_frames(50, 30, 30);

		set_timing(24'd1, 24'd1, 24'd1);
		gap_max = 4;
		rcv_mode = RCV_LIGHT;
		test_random_frames(50, 60, 50);

		// Long pulse shorter than short pulse, and rare offers that starve frames.
		set_timing(24'd9, 24'd4, 24'd2);
		gap_max = 2;
		rcv_mode = RCV_HEAVY;
		test_random_frames(50, 4, 20);

		repeat (4) begin
			set_timing(24'($urandom_range(12, 0)), 24'($urandom_range(5, 0)),
				24'($urandom_range(9, 0)));
			gap_max = $urandom_range(6, 0);
			rcv_mode = rcv_mode_t'($urandom_range(3, 0));
			test_random_frames(50, $urandom_range(40, 2), $urandom_range(80, 5));
		end

		test_backpressure();
		test_longest_lengths();

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_line.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/pwle_pkg.sv
rtl/pwle_front.sv
rtl/pwle_back.sv
rtl/pulse_width_line_encoder.sv
verif/pulse_width_line_encoder_test.sv
